// ===== rtl/lrupr_pkg.sv =====
// Shared types and fixed widths of the LRU page replacement block.
package lrupr_pkg;

  // Fixed field widths.
  localparam int unsigned CfgW    = 7;
  localparam int unsigned IdxOutW = 6;
  localparam int unsigned CntW    = 32;

  // Frame limit after reset.
  localparam logic [CfgW-1:0] CfgReset = 7'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // latch the input item and restart the scan
    logic rd;      // read the next frame entry
    logic commit;  // update the frame tables and load the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;     // no frame loaded yet
    logic last;      // the read being issued is the last loaded frame
    logic out_free;  // the result register can take a new item
  } sts_t;

endpackage

// ===== rtl/lrupr_ctrl.sv =====
// Controller state machine that sequences scan and commit for each item.
module lrupr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lrupr_pkg::sts_t sts_i,
  output lrupr_pkg::cmd_t cmd_o
);
  import lrupr_pkg::*;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StScan   = 4'b0010,
    StDrain  = 4'b0100,
    StFinish = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.empty ? StFinish : StScan;
        end
      end
      StScan: begin
        cmd_o.rd = 1'b1;
        if (sts_i.last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

endmodule

// ===== rtl/lrupr_dp.sv =====
// Datapath with the frame tables, the scan pipeline, the counters and the result register.
module lrupr_dp #(
  parameter int unsigned FRAMES    = 64,
  parameter int unsigned PAGE_BITS = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lrupr_pkg::cmd_t                  cmd_i,
  output lrupr_pkg::sts_t                  sts_o,
  input  logic                             cfg_we_i,
  input  logic [lrupr_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic                             process_id_i,
  input  logic [PAGE_BITS-1:0]             page_number_i,
  input  logic                             is_write_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [lrupr_pkg::IdxOutW-1:0]    frame_index_o,
  output logic                             evicted_o,
  output logic                             evicted_process_o,
  output logic [PAGE_BITS-1:0]             evicted_page_o,
  output logic                             write_back_o,
  output logic [lrupr_pkg::CntW-1:0]       fault_total_o,
  output logic [lrupr_pkg::CntW-1:0]       write_back_total_o
);
  import lrupr_pkg::*;

  localparam int unsigned AW    = $clog2(FRAMES);
  localparam int unsigned CW    = $clog2(FRAMES + 1);
  localparam int unsigned LW    = (CW > CfgW) ? CW : CfgW;
  localparam int unsigned XW    = (AW > IdxOutW) ? AW : IdxOutW;
  localparam int unsigned TAG_W = PAGE_BITS + 2;

  // Tag word layout: owner, page, dirty.
  localparam int unsigned DIRTY_B = 0;
  localparam int unsigned OWNER_B = PAGE_BITS + 1;

  // Frame tables.
  logic [TAG_W-1:0] tag_mem [FRAMES];
  logic [AW-1:0]    age_mem [FRAMES];

  // Configuration and control state.
  logic [CfgW-1:0] cfg_q;
  logic [CW-1:0]   loaded_q;
  logic [CW-1:0]   scan_q;
  logic            s1_vld_q;
  logic [AW-1:0]   s1_idx_q;
  logic [TAG_W-1:0] tag_rd_q;
  logic [AW-1:0]   age_rd_q;

  // Latched input item.
  logic                 pid_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 wr_q;

  // Scan results.
  logic             hit_q;
  logic [AW-1:0]    hit_idx_q;
  logic [AW-1:0]    hit_age_q;
  logic             hit_dirty_q;
  logic             found_q;
  logic [AW-1:0]    max_idx_q;
  logic [AW-1:0]    max_age_q;
  logic [TAG_W-1:0] vic_tag_q;

  // Recency update held back until the next scan applies it.
  logic          pend_vld_q;
  logic [AW-1:0] pend_idx_q;
  logic [AW-1:0] pend_old_q;
  logic          pend_all_q;

  // Counters and result register.
  logic [CntW-1:0] fault_q;
  logic [CntW-1:0] wb_cnt_q;
  logic            out_valid_q;
  logic            res_hit_q;
  logic [AW-1:0]   res_idx_q;
  logic            res_ev_q;
  logic            res_ev_pid_q;
  logic [PAGE_BITS-1:0] res_ev_page_q;
  logic            res_wb_q;

  logic [AW-1:0]    eff_age;
  logic             tag_match;
  logic [LW-1:0]    cfg_ext;
  logic [LW-1:0]    limit;
  logic             free_frame;
  logic [AW-1:0]    commit_idx;
  logic             commit_ev;
  logic             commit_wb;
  logic [TAG_W-1:0] commit_tag;
  logic [XW-1:0]    res_idx_ext;

  // Status toward the controller.
  assign sts_o.empty    = (loaded_q == '0);
  assign sts_o.last     = (CW'(scan_q + 1'b1) == loaded_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Frame limit, clamped to the range the tables can hold.
  always_comb begin
    cfg_ext = LW'(cfg_q);
    if (cfg_ext == '0) begin
      limit = LW'(1);
    end else if (cfg_ext > LW'(FRAMES)) begin
      limit = LW'(FRAMES);
    end else begin
      limit = cfg_ext;
    end
  end
  assign free_frame = LW'(loaded_q) < limit;

  // Age of the entry in the scan stage once the held-back update is applied.
  always_comb begin
    if (!pend_vld_q) begin
      eff_age = age_rd_q;
    end else if (s1_idx_q == pend_idx_q) begin
      eff_age = '0;
    end else if (pend_all_q || (age_rd_q < pend_old_q)) begin
      eff_age = AW'(age_rd_q + 1'b1);
    end else begin
      eff_age = age_rd_q;
    end
  end

  assign tag_match = (tag_rd_q[OWNER_B] == pid_q) &&
                     (tag_rd_q[PAGE_BITS:1] == page_q);

  // Commit decisions: hit frame, next free frame, or least recent frame.
  always_comb begin
    if (hit_q) begin
      commit_idx = hit_idx_q;
    end else if (free_frame) begin
      commit_idx = loaded_q[AW-1:0];
    end else begin
      commit_idx = max_idx_q;
    end
    commit_ev  = !hit_q && !free_frame;
    commit_wb  = commit_ev && vic_tag_q[DIRTY_B];
    commit_tag = {pid_q, page_q, hit_q ? (hit_dirty_q | wr_q) : wr_q};
  end

  // Tag table: read during the scan, written at commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      tag_mem[commit_idx] <= commit_tag;
    end
    tag_rd_q <= tag_mem[scan_q[AW-1:0]];
  end

  // Age table: each scanned entry is written back with its updated age.
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      age_mem[s1_idx_q] <= eff_age;
    end
    age_rd_q <= age_mem[scan_q[AW-1:0]];
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Input item latch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pid_q  <= process_id_i;
      page_q <= page_number_i;
      wr_q   <= is_write_i;
    end
  end

  // Scan address and the read stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.rd;
      if (cmd_i.start) begin
        scan_q <= '0;
      end else if (cmd_i.rd) begin
        scan_q <= CW'(scan_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= scan_q[AW-1:0];
  end

  // Hit search and least recent search over the scanned entries.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      found_q <= 1'b0;
    end else if (cmd_i.start) begin
      hit_q   <= 1'b0;
      found_q <= 1'b0;
    end else if (s1_vld_q) begin
      if (!hit_q && tag_match) begin
        hit_q <= 1'b1;
      end
      if (!found_q || (eff_age > max_age_q)) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      if (!hit_q && tag_match) begin
        hit_idx_q   <= s1_idx_q;
        hit_age_q   <= eff_age;
        hit_dirty_q <= tag_rd_q[DIRTY_B];
      end
      if (!found_q || (eff_age > max_age_q)) begin
        max_idx_q <= s1_idx_q;
        max_age_q <= eff_age;
        vic_tag_q <= tag_rd_q;
      end
    end
  end

  // Held-back recency update, fill count and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      pend_all_q <= 1'b0;
      loaded_q   <= '0;
      fault_q    <= '0;
      wb_cnt_q   <= '0;
    end else if (cmd_i.commit) begin
      pend_vld_q <= 1'b1;
      pend_all_q <= !hit_q && free_frame;
      if (!hit_q && free_frame) begin
        loaded_q <= CW'(loaded_q + 1'b1);
      end
      if (!hit_q && (fault_q != '1)) begin
        fault_q <= fault_q + 1'b1;
      end
      if (commit_wb && (wb_cnt_q != '1)) begin
        wb_cnt_q <= wb_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pend_idx_q <= commit_idx;
      pend_old_q <= hit_q ? hit_age_q : max_age_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_hit_q     <= hit_q;
      res_idx_q     <= commit_idx;
      res_ev_q      <= commit_ev;
      res_ev_pid_q  <= commit_ev & vic_tag_q[OWNER_B];
      res_ev_page_q <= commit_ev ? vic_tag_q[PAGE_BITS:1] : '0;
      res_wb_q      <= commit_wb;
    end
  end

  // Outputs; the counters always show their latest values.
  assign res_idx_ext        = XW'(res_idx_q);
  assign out_valid_o        = out_valid_q;
  assign hit_o              = res_hit_q;
  assign frame_index_o      = res_idx_ext[IdxOutW-1:0];
  assign evicted_o          = res_ev_q;
  assign evicted_process_o  = res_ev_pid_q;
  assign evicted_page_o     = res_ev_page_q;
  assign write_back_o       = res_wb_q;
  assign fault_total_o      = fault_q;
  assign write_back_total_o = wb_cnt_q;

endmodule

// ===== rtl/lru_page_replacement_top.sv =====
// Top level of the LRU page replacement block.
// Each page reference item is checked against every loaded frame by a scan that reads
// one frame entry per cycle from the frame tables over their single read port; an item
// that comes while no frame is loaded skips the scan. A result item that has not been
// taken holds the next item in its final state until it is taken. The recency ranks
// of one reference are folded into the scan of the next one. Frames are filled in index
// order and tracked by a fill count, so no clearing pass follows reset. The counters
// saturate and are shown with every result; frames_in_use is written through cfg_we_i /
// cfg_wdata_i, and the user must write it only while the block is idle, which the block
// itself does not enforce.
module lru_page_replacement_top #(
  parameter int unsigned FRAMES    = 64,
  parameter int unsigned PAGE_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lrupr_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          process_id_i,
  input  logic [PAGE_BITS-1:0]          page_number_i,
  input  logic                          is_write_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [lrupr_pkg::IdxOutW-1:0] frame_index_o,
  output logic                          evicted_o,
  output logic                          evicted_process_o,
  output logic [PAGE_BITS-1:0]          evicted_page_o,
  output logic                          write_back_o,
  output logic [lrupr_pkg::CntW-1:0]    fault_total_o,
  output logic [lrupr_pkg::CntW-1:0]    write_back_total_o
);
  import lrupr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of scan and commit.
  lrupr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Frame tables, counters and result register.
  lrupr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .process_id_i       (process_id_i),
    .page_number_i      (page_number_i),
    .is_write_i         (is_write_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .hit_o              (hit_o),
    .frame_index_o      (frame_index_o),
    .evicted_o          (evicted_o),
    .evicted_process_o  (evicted_process_o),
    .evicted_page_o     (evicted_page_o),
    .write_back_o       (write_back_o),
    .fault_total_o      (fault_total_o),
    .write_back_total_o (write_back_total_o)
  );

endmodule

// ===== tb/sv/lrupr_checker.sv =====
// Checker that predicts the LRU page replacement results and compares them on the output channel.
`timescale 1ns / 100ps

module lrupr_checker #(
  parameter int unsigned FRAMES    = 64,
  parameter int unsigned PAGE_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lrupr_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          process_id_i,
  input  logic [PAGE_BITS-1:0]          page_number_i,
  input  logic                          is_write_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          hit_i,
  input  logic [lrupr_pkg::IdxOutW-1:0] frame_index_i,
  input  logic                          evicted_i,
  input  logic                          evicted_process_i,
  input  logic [PAGE_BITS-1:0]          evicted_page_i,
  input  logic                          write_back_i,
  input  logic [lrupr_pkg::CntW-1:0]    fault_total_i,
  input  logic [lrupr_pkg::CntW-1:0]    write_back_total_i,
  output int                            errors_o,
  output int                            pending_o
);
  import lrupr_pkg::*;

  localparam int unsigned AgeW = $clog2(FRAMES);

  // One expected result item.
  typedef struct packed {
    logic                 hit;
    logic [IdxOutW-1:0]   frame;
    logic                 evicted;
    logic                 ev_owner;
    logic [PAGE_BITS-1:0] ev_page;
    logic                 write_back;
    logic [CntW-1:0]      faults;
    logic [CntW-1:0]      write_backs;
  } page_result_t;

  // Shadow copy of the frame tables, counters and frame limit.
  logic                 res_valid [FRAMES];
  logic                 res_owner [FRAMES];
  logic [PAGE_BITS-1:0] res_page  [FRAMES];
  logic                 res_dirty [FRAMES];
  logic [AgeW-1:0]      res_age   [FRAMES];
  int unsigned          frames_loaded;
  logic [CntW-1:0]      fault_cnt;
  logic [CntW-1:0]      wback_cnt;
  logic [CfgW-1:0]      frame_limit;

  page_result_t         expected_results [$];
  page_result_t         oldest;

  // Make frame f the most recent; every valid frame younger than old_age ages by one.
  function automatic void promote_frame(int f, int old_age);
    for (int i = 0; i < FRAMES; i++) begin
      if (res_valid[i] && i != f && int'(res_age[i]) < old_age) begin
        res_age[i] = res_age[i] + 1'b1;
      end
    end
    res_age[f] = '0;
  endfunction

  // Apply one page reference to the shadow tables and return its result.
  function automatic page_result_t predict_reference(logic pid, logic [PAGE_BITS-1:0] page,
                                                     logic wr);
    page_result_t r;
    int unsigned  eff_limit;
    int           f;
    int           oldest_age;
    bit           found;
    r = '0;
    f = -1;
    eff_limit = frame_limit;
    if (eff_limit < 1) eff_limit = 1;
    if (eff_limit > FRAMES) eff_limit = FRAMES;

    // A hit needs both the owner and the page to match.
    for (int i = 0; i < FRAMES; i++) begin
      if (f < 0 && res_valid[i] && res_owner[i] == pid && res_page[i] == page) f = i;
    end

    if (f >= 0) begin
      r.hit = 1'b1;
      res_dirty[f] = res_dirty[f] | wr;
      promote_frame(f, res_age[f]);
    end else begin
      if (fault_cnt != '1) fault_cnt = fault_cnt + 1'b1;
      if (frames_loaded < eff_limit) begin
        // Free frames are taken in index order.
        f = int'(frames_loaded);
        frames_loaded++;
        res_valid[f] = 1'b1;
        promote_frame(f, FRAMES);
      end else begin
        // Evict the oldest valid frame, the lowest index on a tie.
        found = 1'b0;
        oldest_age = 0;
        for (int i = 0; i < FRAMES; i++) begin
          if (res_valid[i] && (!found || int'(res_age[i]) > oldest_age)) begin
            oldest_age = res_age[i];
            f = i;
            found = 1'b1;
          end
        end
        r.evicted    = 1'b1;
        r.ev_owner   = res_owner[f];
        r.ev_page    = res_page[f];
        r.write_back = res_dirty[f];
        if (res_dirty[f] && wback_cnt != '1) wback_cnt = wback_cnt + 1'b1;
        promote_frame(f, oldest_age);
      end
      res_owner[f] = pid;
      res_page[f]  = page;
      res_dirty[f] = wr;
    end

    r.frame       = f[IdxOutW-1:0];
    r.faults      = fault_cnt;
    r.write_backs = wback_cnt;
    return r;
  endfunction

  // Report a field that differs from its expected value.
  task automatic check_field(string field, logic [CntW-1:0] want, logic [CntW-1:0] got);
    if (want !== got) begin
      errors_o++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  // Watch the configuration port and both channels.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAMES; i++) begin
        res_valid[i] = 1'b0;
        res_owner[i] = 1'b0;
        res_page[i]  = '0;
        res_dirty[i] = 1'b0;
        res_age[i]   = '0;
      end
      frames_loaded = 0;
      fault_cnt     = '0;
      wback_cnt     = '0;
      frame_limit   = CfgReset;
      expected_results.delete();
      errors_o      = 0;
    end else begin
      if (cfg_we_i) frame_limit = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        expected_results.insert(expected_results.size(),
                                predict_reference(process_id_i, page_number_i, is_write_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          errors_o++;
          $display("%0t: result item with none expected, frame %0h hit %0b", $time,
                   frame_index_i, hit_i);
        end else begin
          oldest = expected_results.pop_front();
          check_field("hit", oldest.hit, hit_i);
          check_field("frame_index", oldest.frame, frame_index_i);
          check_field("evicted", oldest.evicted, evicted_i);
          check_field("evicted_process", oldest.ev_owner, evicted_process_i);
          check_field("evicted_page", oldest.ev_page, evicted_page_i);
          check_field("write_back", oldest.write_back, write_back_i);
          check_field("fault_total", oldest.faults, fault_total_i);
          check_field("write_back_total", oldest.write_backs, write_back_total_i);
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top that drives page references and frame limits into the LRU page replacement block.
`timescale 1ns / 100ps

module tb;
  import lrupr_pkg::*;

  localparam int unsigned Frames   = 64;
  localparam int unsigned PageBits = 20;
  localparam int unsigned PoolSize = 96;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CfgW-1:0]     cfg_wdata   = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic                process_id  = 1'b0;
  logic [PageBits-1:0] page_number = '0;
  logic                is_write    = 1'b0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic                hit;
  logic [IdxOutW-1:0]  frame_index;
  logic                evicted;
  logic                evicted_process;
  logic [PageBits-1:0] evicted_page;
  logic                write_back;
  logic [CntW-1:0]     fault_total;
  logic [CntW-1:0]     write_back_total;

  int                  errors;
  int                  pending;
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;

  // Working set of references that random items draw from, so that hits are frequent.
  logic [PageBits-1:0] pool_page [PoolSize];
  logic                pool_owner [PoolSize];

  // Frame limit of each random phase.
  logic [CfgW-1:0]     phase_limit [8] = '{7'd64, 7'd5, 7'd1, 7'd100, 7'd64, 7'd16, 7'd127, 7'd2};

  lru_page_replacement_top #(
    .FRAMES   (Frames),
    .PAGE_BITS(PageBits)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .process_id_i      (process_id),
    .page_number_i     (page_number),
    .is_write_i        (is_write),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .hit_o             (hit),
    .frame_index_o     (frame_index),
    .evicted_o         (evicted),
    .evicted_process_o (evicted_process),
    .evicted_page_o    (evicted_page),
    .write_back_o      (write_back),
    .fault_total_o     (fault_total),
    .write_back_total_o(write_back_total)
  );

  lrupr_checker #(
    .FRAMES   (Frames),
    .PAGE_BITS(PageBits)
  ) u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .process_id_i      (process_id),
    .page_number_i     (page_number),
    .is_write_i        (is_write),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .hit_i             (hit),
    .frame_index_i     (frame_index),
    .evicted_i         (evicted),
    .evicted_process_i (evicted_process),
    .evicted_page_i    (evicted_page),
    .write_back_i      (write_back),
    .fault_total_i     (fault_total),
    .write_back_total_i(write_back_total),
    .errors_o          (errors),
    .pending_o         (pending)
  );

  // Clock with an 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #8_000_000;
    $display("tb: errors");
    $finish;
  end

  // The result side stalls at the rate set for the current phase.
  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Present one page reference item and hold it until it is accepted.
  task automatic send_ref(logic pid, logic [PageBits-1:0] page, logic wr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    process_id  <= pid;
    page_number <= page;
    is_write    <= wr;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain(int extra_cycles);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (extra_cycles) @(posedge clk);
  endtask

  // Write the frame limit; the block is idle whenever this is called.
  task automatic set_limit(logic [CfgW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random references, mostly from the first span entries of the working set.
  task automatic run_phase(int items, int span, bit pause_midway);
    int k;
    for (int n = 0; n < items; n++) begin
      if (pause_midway && n == items / 2) drain(1);
      if ($urandom_range(99) < 12) begin
        send_ref(1'($urandom_range(1)), PageBits'($urandom), 1'($urandom_range(1)));
      end else begin
        k = $urandom_range(span - 1);
        send_ref(pool_owner[k] ^ ($urandom_range(9) == 0), pool_page[k],
                 1'($urandom_range(1)));
      end
    end
  endtask

  // Main sequence: reset, directed references, then random phases.
  initial begin
    pool_page[0]  = '0;
    pool_owner[0] = 1'b0;
    pool_page[1]  = '1;
    pool_owner[1] = 1'b1;
    for (int i = 2; i < PoolSize; i++) begin
      pool_page[i]  = PageBits'($urandom);
      pool_owner[i] = 1'($urandom_range(1));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A limit of zero behaves as a single frame.
    set_limit(7'd0);
    send_ref(1'b0, 20'h00000, 1'b0);
    send_ref(1'b0, 20'h00000, 1'b1);
    // Same page, other process: must miss and write back the dirty frame.
    send_ref(1'b1, 20'h00000, 1'b0);
    send_ref(1'b1, 20'hFFFFF, 1'b1);
    send_ref(1'b1, 20'hFFFFF, 1'b0);
    drain(4);

    // Three frames: fill the free ones, then evict by age.
    set_limit(7'd3);
    send_ref(1'b0, 20'h55555, 1'b1);
    send_ref(1'b0, 20'hAAAAA, 1'b0);
    send_ref(1'b1, 20'hFFFFF, 1'b0);
    send_ref(1'b0, 20'h12345, 1'b0);
    send_ref(1'b0, 20'hAAAAA, 1'b1);
    send_ref(1'b1, 20'h00001, 1'b1);
    drain(4);

    // A limit above the frame count behaves as the full count.
    set_limit(7'd127);
    send_ref(1'b1, 20'h00F0F, 1'b0);
    send_ref(1'b0, 20'h0F0F0, 1'b1);
    send_ref(1'b1, 20'h33333, 1'b0);
    drain(4);

    // Limit lowered below the loaded frames: they stay resident and still hit.
    set_limit(7'd2);
    send_ref(1'b0, 20'h77777, 1'b0);
    send_ref(1'b0, 20'h0F0F0, 1'b0);
    send_ref(1'b1, 20'h33333, 1'b1);
    send_ref(1'b1, 20'h88888, 1'b0);
    drain(4);

    // Random phases under different limits and idling patterns.
    for (int p = 0; p < 8; p++) begin
      set_limit(phase_limit[p]);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  = 53;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 53;
        end
        default: begin
          send_idle_pct  = 26;
          recv_stall_pct <= 26;
        end
      endcase
      run_phase(106, (p % 3 == 0) ? 16 : ((p % 3 == 1) ? 70 : PoolSize), p == 2 || p == 5);
      drain(4);
    end

    drain(70);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
